// ----- rtl/core/cdt_pkg.sv -----
package cdt_pkg;

    // Field and register widths
    localparam int STAMP_W     = 32;
    localparam int THRESH_W    = 16;
    localparam int STEP_W      = 12;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int MODE_CODE_W = 2;
    localparam int BANNER_W    = 3;
    localparam int REMAIN_W    = 13;
    localparam int MIN_W       = 7;
    localparam int SEC_W       = 6;

    localparam int MAX_SECONDS_DEFAULT = 5999;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SET_STEP       = 1'b1;
    localparam logic [THRESH_W-1:0]    THRESH_RESET       = 16'd1000;
    localparam logic [STEP_W-1:0]      STEP_RESET         = 12'd60;

    // Split by 60: q = (x * DIV60_MUL) >> DIV60_SHIFT, exact for any 16-bit x
    localparam int DIV_W       = 16;
    localparam int DIV60_MUL_W = 17;
    localparam int DIV60_SHIFT = 22;
    localparam int QUOT_W      = 11;
    localparam logic [DIV60_MUL_W-1:0] DIV60_MUL = 17'd69906;

    // Mode output codes
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_IDLE  = 2'd0;
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_SET   = 2'd1;
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_COUNT = 2'd2;
    localparam logic [MODE_CODE_W-1:0] MODE_CODE_PAUSE = 2'd3;

    // Banner codes
    localparam logic [BANNER_W-1:0] BANNER_NONE      = 3'd0;
    localparam logic [BANNER_W-1:0] BANNER_SET_TIME  = 3'd1;
    localparam logic [BANNER_W-1:0] BANNER_TIME_SET  = 3'd2;
    localparam logic [BANNER_W-1:0] BANNER_COUNTDOWN = 3'd3;
    localparam logic [BANNER_W-1:0] BANNER_PAUSE     = 3'd4;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_SET   = 4'b0010,
        MODE_COUNT = 4'b0100,
        MODE_PAUSE = 4'b1000
    } mode_t;

    typedef struct packed {
        logic start_short;
        logic start_long;
        logic stop_short;
        logic stop_long;
    } press_t;

    typedef struct packed {
        mode_t                 mode;
        logic [BANNER_W-1:0]   banner;
        logic                  clear;
    } pass_status_t;

    function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_CODE_W-1:0] code;
        unique case (m)
            MODE_IDLE:  code = MODE_CODE_IDLE;
            MODE_SET:   code = MODE_CODE_SET;
            MODE_COUNT: code = MODE_CODE_COUNT;
            MODE_PAUSE: code = MODE_CODE_PAUSE;
            default:    code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/cdt_mode_fsm.sv -----
module cdt_mode_fsm
    import cdt_pkg::*;
#(
    parameter int MAX_SECONDS = MAX_SECONDS_DEFAULT,
    parameter int TIME_W      = $clog2(MAX_SECONDS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic [STAMP_W-1:0]  millis_now,
    input  press_t              press,
    input  logic [THRESH_W-1:0] tick_threshold,
    input  logic [STEP_W-1:0]   set_step,
    output logic [TIME_W-1:0]   time_out,
    output pass_status_t        status
);

    localparam int SUM_W = ((TIME_W > STEP_W) ? TIME_W : STEP_W) + 1;

    mode_t               mode_reg, mode_next;
    logic                entered_reg, entered_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [BANNER_W-1:0] banner;
    logic [SUM_W-1:0]    sum;
    logic [STAMP_W-1:0]  elapsed;
    logic                clear;

    always_comb
    begin
        time_next  = time_reg;
        stamp_next = stamp_reg;
        banner     = BANNER_NONE;
        mode_next  = mode_reg;
        sum        = '0;
        elapsed    = '0;

        // entry action on the first pass in a mode
        if (!entered_reg)
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    time_next  = '0;
                    stamp_next = '0;
                    banner     = BANNER_SET_TIME;
                end
                MODE_SET:   banner = BANNER_TIME_SET;
                MODE_COUNT:
                begin
                    stamp_next = millis_now;
                    banner     = BANNER_COUNTDOWN;
                end
                MODE_PAUSE: banner = BANNER_PAUSE;
                default:    banner = BANNER_NONE;
            endcase
        end

        // during rule
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (press.start_short)
                    mode_next = MODE_SET;
            end
            MODE_SET:
            begin
                if (press.start_short)
                begin
                    sum = SUM_W'(time_next) + SUM_W'(set_step);
                    if (sum > SUM_W'(MAX_SECONDS))
                        time_next = TIME_W'(MAX_SECONDS);
                    else
                        time_next = TIME_W'(sum);
                end
                if (press.stop_short)
                begin
                    if (SUM_W'(set_step) >= SUM_W'(time_next))
                        time_next = '0;
                    else
                        time_next = TIME_W'(SUM_W'(time_next) - SUM_W'(set_step));
                end
                if (press.start_long)
                    mode_next = MODE_COUNT;
            end
            MODE_COUNT:
            begin
                elapsed = millis_now - stamp_next;
                if (elapsed > STAMP_W'(tick_threshold))
                begin
                    if (time_next != '0)
                        time_next = time_next - TIME_W'(1);
                    stamp_next = millis_now;
                end
                if (time_next == '0 || press.stop_short)
                    mode_next = MODE_IDLE;
                if (press.start_short)
                    mode_next = MODE_PAUSE;
            end
            MODE_PAUSE:
            begin
                if (press.start_short)
                    mode_next = MODE_COUNT;
                if (press.start_long)
                    mode_next = MODE_SET;
                if (press.stop_long)
                    mode_next = MODE_IDLE;
            end
            default: mode_next = MODE_IDLE;
        endcase

        clear        = (mode_next != mode_reg);
        entered_next = !clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            entered_reg <= 1'b0;
            time_reg    <= '0;
            stamp_reg   <= '0;
        end
        else if (enable)
        begin
            mode_reg    <= mode_next;
            entered_reg <= entered_next;
            time_reg    <= time_next;
            stamp_reg   <= stamp_next;
        end
    end

    assign time_out      = time_next;
    assign status.mode   = mode_next;
    assign status.banner = banner;
    assign status.clear  = clear;

endmodule

// ----- rtl/core/cdt_out_stage.sv -----
module cdt_out_stage
    import cdt_pkg::*;
#(
    parameter int MAX_SECONDS = MAX_SECONDS_DEFAULT,
    parameter int TIME_W      = $clog2(MAX_SECONDS + 1)
)
(
    input  logic                   clk,
    input  logic                   load,
    input  logic [TIME_W-1:0]      time_in,
    input  pass_status_t           status_in,
    output logic [MODE_CODE_W-1:0] mode_now,
    output logic [REMAIN_W-1:0]    remaining_seconds,
    output logic [MIN_W-1:0]       shown_minutes,
    output logic [SEC_W-1:0]       shown_seconds,
    output logic [BANNER_W-1:0]    banner_code,
    output logic                   clear_display
);

    localparam int PROD_W = DIV_W + DIV60_MUL_W;

    logic [DIV_W-1:0]  x;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [DIV_W-1:0]  quot_ext;
    logic [DIV_W-1:0]  rem_full;

    // split into minutes and seconds by reciprocal multiply
    always_comb
    begin
        x        = DIV_W'(time_in);
        prod     = PROD_W'(x) * PROD_W'(DIV60_MUL);
        quot     = QUOT_W'(prod >> DIV60_SHIFT);
        quot_ext = DIV_W'(quot);
        rem_full = x - ((quot_ext << 6) - (quot_ext << 2));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_now          <= mode_code(status_in.mode);
            remaining_seconds <= REMAIN_W'(time_in);
            shown_minutes     <= MIN_W'(quot);
            shown_seconds     <= SEC_W'(rem_full);
            banner_code       <= status_in.banner;
            clear_display     <= status_in.clear;
        end
    end

endmodule

// ----- rtl/core/countdown_timer_controller.sv -----
// Countdown timer mode controller. Each input item is one pass of the timer
// task: the running millisecond count plus qualified short/long press flags
// for the start and stop buttons. Every item yields exactly one result item
// carrying the mode after the pass, the set or remaining time (also split into
// minutes and seconds), the banner written on mode entry and a display-clear
// flag raised when a mode is left. Items flow through three register stages:
// an input register, the mode/time state update into a middle register, and
// the minutes/seconds split into the result register. One item is accepted
// per cycle while in_stall stays low, limited by the state update loop. Write
// tick_threshold_ms and set_step_seconds through the cfg port only while no
// item is in flight.
module countdown_timer_controller
    import cdt_pkg::*;
#(
    parameter int MAX_SECONDS = MAX_SECONDS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // input item channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [STAMP_W-1:0]     millis_now,
    input  logic                   start_short,
    input  logic                   start_long,
    input  logic                   stop_short,
    input  logic                   stop_long,

    // result item channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MODE_CODE_W-1:0] mode_now,
    output logic [REMAIN_W-1:0]    remaining_seconds,
    output logic [MIN_W-1:0]       shown_minutes,
    output logic [SEC_W-1:0]       shown_seconds,
    output logic [BANNER_W-1:0]    banner_code,
    output logic                   clear_display
);

    localparam int TIME_W = $clog2(MAX_SECONDS + 1);

    // configuration registers
    logic [THRESH_W-1:0] thresh_reg;
    logic [STEP_W-1:0]   step_reg;

    // pipeline valid bits
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;

    // input register payload
    logic [STAMP_W-1:0] millis_reg;
    press_t             press_reg;

    // middle register payload
    logic [TIME_W-1:0]  mid_time_reg;
    pass_status_t       mid_status_reg;

    // state update results
    logic [TIME_W-1:0]  upd_time;
    pass_status_t       upd_status;

    logic in_accept;
    logic out_load;
    logic mid_free;
    logic in_move;

    // Advance each stage when the one after it can take the item.
    assign out_load  = mid_valid_reg && (!out_valid_reg || !out_stall);
    assign mid_free  = !mid_valid_reg || out_load;
    assign in_move   = in_valid_reg && mid_free;
    assign in_stall  = in_valid_reg && !mid_free;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Hold configuration; drop writes to unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_TICK_THRESHOLD: thresh_reg <= THRESH_W'(cfg_data);
                REG_SET_STEP:       step_reg   <= STEP_W'(cfg_data);
                default:            thresh_reg <= thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (in_move)
                in_valid_reg <= 1'b0;

            if (in_move)
                mid_valid_reg <= 1'b1;
            else if (out_load)
                mid_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the item.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            millis_reg            <= millis_now;
            press_reg.start_short <= start_short;
            press_reg.start_long  <= start_long;
            press_reg.stop_short  <= stop_short;
            press_reg.stop_long   <= stop_long;
        end
    end

    // Mode and time state; updates once per item leaving the input register.
    cdt_mode_fsm #(
        .MAX_SECONDS (MAX_SECONDS),
        .TIME_W      (TIME_W)
    ) u_mode_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (in_move),
        .millis_now     (millis_reg),
        .press          (press_reg),
        .tick_threshold (thresh_reg),
        .set_step       (step_reg),
        .time_out       (upd_time),
        .status         (upd_status)
    );

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            mid_time_reg   <= upd_time;
            mid_status_reg <= upd_status;
        end
    end

    // Split the time for display and hold the result item.
    cdt_out_stage #(
        .MAX_SECONDS (MAX_SECONDS),
        .TIME_W      (TIME_W)
    ) u_out_stage (
        .clk               (clk),
        .load              (out_load),
        .time_in           (mid_time_reg),
        .status_in         (mid_status_reg),
        .mode_now          (mode_now),
        .remaining_seconds (remaining_seconds),
        .shown_minutes     (shown_minutes),
        .shown_seconds     (shown_seconds),
        .banner_code       (banner_code),
        .clear_display     (clear_display)
    );

endmodule
